### hw/rtl/dpc_pkg.sv
// Shared types and constants for the deadband position controller.
package dpc_pkg;

  // Field widths fixed by the interface
  localparam int POS_W = 20;
  localparam int CFG_W = 12;
  localparam int TOL_W = 7;
  localparam int DRV_W = 8;
  localparam int ST_W  = 2;

  // Command codes
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_GOAL  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_FORCE = 2'd3
  } mode_t;

  // Motor state codes (code 3 is unused)
  localparam logic [ST_W-1:0] ST_READY   = 2'd0;
  localparam logic [ST_W-1:0] ST_MOVING  = 2'd1;
  localparam logic [ST_W-1:0] ST_STALLED = 2'd2;

  // Drive levels
  localparam logic [DRV_W-1:0] DRV_FULL = 8'd255;
  localparam logic [DRV_W-1:0] DRV_OFF  = 8'd0;

  // Percent saturation limits
  localparam logic [POS_W-1:0] PCT_MAX     = 20'h7FFFF;
  localparam logic [POS_W-1:0] PCT_MIN     = 20'h80000;
  localparam int               PCT_POS_MAG = 524287;
  localparam int               PCT_NEG_MAG = 524288;

  // Config register indexes
  localparam logic [1:0] REG_MIN = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;
  localparam logic [1:0] REG_TOL = 2'd2;

  // Result of one control-law update
  typedef struct packed {
    logic [DRV_W-1:0] drive_a;
    logic [DRV_W-1:0] drive_b;
    logic [ST_W-1:0]  motor_state;
  } law_out_t;

endpackage

### hw/rtl/dpc_div.sv
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit per cycle.
module dpc_div #(
  parameter int NUM_BITS = 19,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] den;
  logic [CNT_W-1:0]    count;

  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS+1:0] trial;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem, quo[NUM_BITS-1]};
    trial   = {1'b0, shifted} - {2'b00, den};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_BITS-2:0], ~trial[DEN_BITS+1]};
      rem <= trial[DEN_BITS+1] ? shifted[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign quotient = quo;

endmodule

### hw/rtl/dpc_law.sv
// Control state, goal and drive levels; bang-bang law with an open deadband.
module dpc_law (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 commit,
  input  dpc_pkg::mode_t                       cmd,
  input  logic signed [dpc_pkg::POS_W-1:0]     pos,
  input  logic signed [dpc_pkg::POS_W-1:0]     goal_in,
  input  logic [dpc_pkg::ST_W-1:0]             force_state,
  input  logic [dpc_pkg::TOL_W-1:0]            tol,
  output dpc_pkg::law_out_t                    nxt
);

  logic [dpc_pkg::ST_W-1:0]           ctrl_state;
  logic signed [dpc_pkg::POS_W-1:0]   goal;
  logic [dpc_pkg::DRV_W-1:0]          drv_a;
  logic [dpc_pkg::DRV_W-1:0]          drv_b;

  logic [dpc_pkg::ST_W-1:0]           ctrl_state_next;
  logic signed [dpc_pkg::POS_W-1:0]   goal_next;
  logic [dpc_pkg::DRV_W-1:0]          drv_a_next;
  logic [dpc_pkg::DRV_W-1:0]          drv_b_next;

  logic signed [dpc_pkg::POS_W:0]     delta;
  logic [dpc_pkg::POS_W:0]            mag;
  logic                               outside;
  logic                               in_band;
  logic                               above;

  // Error against goal; band test is |delta| < tol, moving is |delta| > tol
  always_comb begin
    delta   = {pos[dpc_pkg::POS_W-1], pos} - {goal[dpc_pkg::POS_W-1], goal};
    mag     = delta[dpc_pkg::POS_W] ? -delta : delta;
    outside = mag > (dpc_pkg::POS_W+1)'(tol);
    in_band = mag < (dpc_pkg::POS_W+1)'(tol);
    above   = !delta[dpc_pkg::POS_W] && (delta != '0);
  end

  // Next state per command
  always_comb begin
    ctrl_state_next = ctrl_state;
    goal_next       = goal;
    drv_a_next      = drv_a;
    drv_b_next      = drv_b;
    case (cmd)
      dpc_pkg::MODE_TICK: begin
        if (ctrl_state inside {dpc_pkg::ST_READY, dpc_pkg::ST_MOVING}) begin
          ctrl_state_next = outside ? dpc_pkg::ST_MOVING : dpc_pkg::ST_READY;
          if (in_band) begin
            drv_a_next = dpc_pkg::DRV_OFF;
            drv_b_next = dpc_pkg::DRV_OFF;
          end else if (above) begin
            drv_a_next = dpc_pkg::DRV_FULL;
            drv_b_next = dpc_pkg::DRV_OFF;
          end else begin
            drv_a_next = dpc_pkg::DRV_OFF;
            drv_b_next = dpc_pkg::DRV_FULL;
          end
        end else if (ctrl_state == dpc_pkg::ST_STALLED) begin
          drv_a_next = dpc_pkg::DRV_OFF;
          drv_b_next = dpc_pkg::DRV_OFF;
        end
      end
      dpc_pkg::MODE_GOAL: begin
        goal_next       = goal_in;
        ctrl_state_next = dpc_pkg::ST_MOVING;
      end
      dpc_pkg::MODE_INIT: begin
        goal_next = pos;
      end
      dpc_pkg::MODE_FORCE: begin
        // unused code leaves the state alone
        if (force_state inside {dpc_pkg::ST_READY, dpc_pkg::ST_MOVING,
                                dpc_pkg::ST_STALLED}) begin
          ctrl_state_next = force_state;
        end
      end
      default: begin
        ctrl_state_next = ctrl_state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state <= dpc_pkg::ST_READY;
      goal       <= '0;
      drv_a      <= dpc_pkg::DRV_OFF;
      drv_b      <= dpc_pkg::DRV_OFF;
    end else if (commit) begin
      ctrl_state <= ctrl_state_next;
      goal       <= goal_next;
      drv_a      <= drv_a_next;
      drv_b      <= drv_b_next;
    end
  end

  assign nxt.drive_a     = drv_a_next;
  assign nxt.drive_b     = drv_b_next;
  assign nxt.motor_state = ctrl_state_next;

endmodule

### hw/rtl/deadband_position_controller.sv
// Top level: command sequencer, percent conversion and result register.
// A sample tick or init command converts the sample to travel percent,
// 100*(sample-min)/(max-min) truncated toward zero and saturated to 20 bits,
// through a bit-serial divider that produces one quotient bit per cycle; such
// a command passes through prepare, load, divide, fix and apply, the divider
// running W+7 steps, W being the wider of SAMPLE_BITS and 12. With a zero span
// the divider is skipped, span_error is set and the percent is 0. Set goal and
// force state skip the divider and go straight to apply.
// One command is in work at a time; a finished result sits in the output
// register while the next command is taken in. Configuration is to be written
// only while idle; the block itself does not enforce this.
module deadband_position_controller #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [dpc_pkg::CFG_W-1:0]         cfg_data,
  // command channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [SAMPLE_BITS-1:0]            sample,
  input  logic signed [dpc_pkg::POS_W-1:0]  goal_percent,
  input  logic [dpc_pkg::ST_W-1:0]          target_state,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dpc_pkg::DRV_W-1:0]         drive_a,
  output logic [dpc_pkg::DRV_W-1:0]         drive_b,
  output logic [dpc_pkg::ST_W-1:0]          motor_state,
  output logic signed [dpc_pkg::POS_W-1:0]  position_percent,
  output logic                              span_error
);

  // offset magnitude covers both the sample and the config registers
  localparam int DIF_W  = (SAMPLE_BITS > dpc_pkg::CFG_W) ? SAMPLE_BITS : dpc_pkg::CFG_W;
  localparam int NUM_W  = DIF_W + 7;
  localparam int DEN_W  = dpc_pkg::CFG_W;
  localparam int WIDE_W = (NUM_W > dpc_pkg::POS_W + 1) ? NUM_W : dpc_pkg::POS_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_LOAD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_FIX   = 6'b010000,
    S_APPLY = 6'b100000
  } fsm_t;

  fsm_t state;

  // Config registers
  logic [DEN_W-1:0]          min_pos;
  logic [DEN_W-1:0]          max_pos;
  logic [dpc_pkg::TOL_W-1:0] tol;

  // Captured command
  dpc_pkg::mode_t                    cmd;
  logic [SAMPLE_BITS-1:0]            smp;
  logic signed [dpc_pkg::POS_W-1:0]  goal_in;
  logic [dpc_pkg::ST_W-1:0]          force_st;

  // Working values
  logic                              num_neg;
  logic [DIF_W-1:0]                  dmag;
  logic                              den_neg;
  logic [DEN_W-1:0]                  den_mag;
  logic signed [dpc_pkg::POS_W-1:0]  pos;
  logic                              zero_span;

  logic [DIF_W:0]         diff;
  logic [DIF_W:0]         diff_neg;
  logic [DEN_W:0]         span;
  logic [DEN_W:0]         span_neg;
  logic [NUM_W-1:0]       num100;
  logic [NUM_W-1:0]       qmag;
  logic [WIDE_W-1:0]      qwide;
  logic                   div_busy;
  logic                   in_xfer;
  logic                   out_free;
  logic                   commit;
  dpc_pkg::law_out_t      law_nxt;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == S_APPLY) && out_free;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pos <= '0;
      max_pos <= 12'd4095;
      tol     <= 7'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        dpc_pkg::REG_MIN: min_pos <= cfg_data;
        dpc_pkg::REG_MAX: max_pos <= cfg_data;
        dpc_pkg::REG_TOL: tol     <= cfg_data[dpc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Offset from min and span, both as sign and magnitude
  always_comb begin
    diff     = (DIF_W+1)'(smp) - (DIF_W+1)'(min_pos);
    diff_neg = -diff;
    span     = {1'b0, max_pos} - {1'b0, min_pos};
    span_neg = -span;
  end

  // Times 100 as 64 + 32 + 4
  assign num100 = (NUM_W'(dmag) << 6) + (NUM_W'(dmag) << 5) + (NUM_W'(dmag) << 2);

  dpc_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (num100),
    .divisor  (den_mag),
    .busy     (div_busy),
    .quotient (qmag)
  );

  assign qwide = WIDE_W'(qmag);

  dpc_law u_law (
    .clk         (clk),
    .rst         (rst),
    .commit      (commit),
    .cmd         (cmd),
    .pos         (pos),
    .goal_in     (goal_in),
    .force_state (force_st),
    .tol         (tol),
    .nxt         (law_nxt)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (mode inside {dpc_pkg::MODE_TICK, dpc_pkg::MODE_INIT}) begin
              state <= S_PREP;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_PREP:  state <= (span == '0) ? S_APPLY : S_LOAD;
        S_LOAD:  state <= S_DIV;
        S_DIV:   if (!div_busy) state <= S_FIX;
        S_FIX:   state <= S_APPLY;
        S_APPLY: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command capture and percent datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd       <= dpc_pkg::mode_t'(mode);
      smp       <= sample;
      goal_in   <= goal_percent;
      force_st  <= target_state;
      pos       <= '0;
      zero_span <= 1'b0;
    end
    if (state == S_PREP) begin
      num_neg   <= diff[DIF_W];
      dmag      <= diff[DIF_W] ? diff_neg[DIF_W-1:0] : diff[DIF_W-1:0];
      den_neg   <= span[DEN_W];
      den_mag   <= span[DEN_W] ? span_neg[DEN_W-1:0] : span[DEN_W-1:0];
      zero_span <= (span == '0);
    end
    // Sign and saturation of the quotient
    if (state == S_FIX) begin
      if (!(num_neg ^ den_neg)) begin
        pos <= (qwide > WIDE_W'(dpc_pkg::PCT_POS_MAG)) ? dpc_pkg::PCT_MAX
                                                       : qwide[dpc_pkg::POS_W-1:0];
      end else begin
        pos <= (qwide > WIDE_W'(dpc_pkg::PCT_NEG_MAG)) ? dpc_pkg::PCT_MIN
                                                       : -qwide[dpc_pkg::POS_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      drive_a          <= law_nxt.drive_a;
      drive_b          <= law_nxt.drive_b;
      motor_state      <= law_nxt.motor_state;
      position_percent <= pos;
      span_error       <= zero_span;
    end
  end

endmodule
